// ===== rtl/core/mhsic_pkg.sv =====
// Package for the magnetometer hard/soft-iron calibration block.
// Holds the mode and sequencer types, status codes and the lane control struct.
// No dependencies.
`default_nettype none

package mhsic_pkg;

   localparam int SAMPLE_W = 16;
   localparam logic [15:0] CAL_SAMPLES_RESET = 16'd2000;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_CAL  = 2'd1,
      MODE_DONE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } fsm_type;

   typedef logic [1:0] status_type;

   localparam status_type STAT_PASS   = 2'd0;
   localparam status_type STAT_CAL    = 2'd1;
   localparam status_type STAT_FINISH = 2'd2;
   localparam status_type STAT_CORR   = 2'd3;

   typedef struct packed {
      logic ld_held;
      logic track;
      logic clr_track;
      logic ld_off;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/mag_hard_soft_iron_calibration.sv =====
// Three-axis magnetometer min/max hard- and soft-iron calibration, top level.
// Pass-through, start and calibrating samples go from idle to the emit state; corrected
// samples pass the subtract and multiply states first; the sample that finishes
// calibration waits in the divide state on two serial dividers, one quotient bit a cycle.
// One item is in process at a time. Synchronous reset clears mode, count, held readings,
// min/max and offsets, sets both gains to one and loads cal_samples with 2000.
`default_nettype none

module mag_hard_soft_iron_calibration #(
   parameter int GAIN_FRAC_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // raw_x, raw_y, raw_z
   input  wire logic [1:0]  req_tuser,  // req_type, overflow
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // out_x, out_y, out_z
   output logic [1:0]       rsp_tuser   // status
);
   import mhsic_pkg::*;

   localparam int GW = GAIN_FRAC_BITS + 4;
   localparam logic [GW-1:0] GAIN_ONE = GW'(64'd1 << GAIN_FRAC_BITS);

   fsm_type      state_ff, state_in;
   mode_type     mode_ff, mode_in;
   logic [15:0]  count_ff, count_in;
   logic [15:0]  cal_samples_ff;
   status_type   stat_ff, stat_in;
   logic [GW-1:0] gain_y_ff, gain_y_in;
   logic [GW-1:0] gain_z_ff, gain_z_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [47:0]  rsp_data_ff, rsp_data_in;
   status_type   rsp_user_ff, rsp_user_in;

   lane_ctl_type ctl;
   logic         accept;
   logic         div_start;
   logic [15:0]  cnt_inc;
   logic signed [15:0] held_x, held_y, held_z;
   logic signed [15:0] corr_x, corr_y, corr_z;
   logic [15:0]  rng_x, rng_y, rng_z;
   logic         busy_y, busy_z;
   logic [GW-1:0] div_gain_y, div_gain_z;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cnt_inc    = count_ff + 16'd1;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      stat_in      = stat_ff;
      gain_y_in    = gain_y_ff;
      gain_z_in    = gain_z_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ctl          = '0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EMIT;
               if (req_tuser[0]) begin
                  stat_in = STAT_CAL;
                  if (mode_ff != MODE_CAL) begin
                     ctl.clr_track = 1'b1;
                     count_in      = '0;
                     mode_in       = MODE_CAL;
                  end
               end else begin
                  ctl.ld_held = ~req_tuser[1];
                  case (mode_ff)
                     MODE_CAL: begin
                        if (cnt_inc < cal_samples_ff) begin
                           ctl.track = 1'b1;
                           count_in  = cnt_inc;
                           stat_in   = STAT_CAL;
                        end else begin
                           ctl.ld_off    = 1'b1;
                           ctl.clr_track = 1'b1;
                           div_start     = 1'b1;
                           count_in      = '0;
                           mode_in       = MODE_DONE;
                           stat_in       = STAT_FINISH;
                           state_in      = ST_DIV;
                        end
                     end
                     MODE_DONE: begin
                        stat_in  = STAT_CORR;
                        state_in = ST_SUB;
                     end
                     default: begin
                        stat_in = STAT_PASS;
                     end
                  endcase
               end
            end
         end
         ST_SUB: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_DIV: begin
            if (!busy_y && !busy_z) begin
               gain_y_in = div_gain_y;
               gain_z_in = div_gain_z;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = stat_ff;
               if (stat_ff == STAT_CORR) begin
                  rsp_data_in = {corr_z, corr_y, corr_x};
               end else begin
                  rsp_data_in = {held_z, held_y, held_x};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= MODE_IDLE;
         count_ff       <= '0;
         cal_samples_ff <= CAL_SAMPLES_RESET;
         gain_y_ff      <= GAIN_ONE;
         gain_z_ff      <= GAIN_ONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         gain_y_ff    <= gain_y_in;
         gain_z_ff    <= gain_z_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cal_samples_ff <= csr_wdata;
         end
      end
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   mhsic_lane #(.FRAC(GAIN_FRAC_BITS), .NEGATE(1'b1)) u_lane_x (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .raw   (req_tdata[15:0]),
      .gain  (GAIN_ONE),
      .held  (held_x),
      .corr  (corr_x),
      .rng   (rng_x)
   );

   mhsic_lane #(.FRAC(GAIN_FRAC_BITS), .NEGATE(1'b1)) u_lane_y (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .raw   (req_tdata[31:16]),
      .gain  (gain_y_ff),
      .held  (held_y),
      .corr  (corr_y),
      .rng   (rng_y)
   );

   mhsic_lane #(.FRAC(GAIN_FRAC_BITS), .NEGATE(1'b0)) u_lane_z (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .raw   (req_tdata[47:32]),
      .gain  (gain_z_ff),
      .held  (held_z),
      .corr  (corr_z),
      .rng   (rng_z)
   );

   mhsic_div #(.FRAC(GAIN_FRAC_BITS)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rng_x),
      .den   (rng_y),
      .busy  (busy_y),
      .gain  (div_gain_y)
   );

   mhsic_div #(.FRAC(GAIN_FRAC_BITS)) u_div_z (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rng_x),
      .den   (rng_z),
      .busy  (busy_z),
      .gain  (div_gain_z)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input accepted while an item is still in process");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (busy_y || busy_z) |-> state_ff == ST_DIV)
      else $error("gain divider busy outside the divide state");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_CAL |-> count_ff == '0)
      else $error("sample count nonzero outside calibration");

   a_gain_untouched: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> gain_y_ff == GAIN_ONE && gain_z_ff == GAIN_ONE)
      else $error("gains changed before any calibration finished");

endmodule

`default_nettype wire

// ===== rtl/core/mhsic_div.sv =====
// Restoring serial divider that forms one soft-iron gain, one quotient bit per cycle.
// Saturates on a zero divisor or a quotient above the unsigned Q4.FRAC format. Uses mhsic_pkg.
`default_nettype none

module mhsic_div #(
   parameter int FRAC = 14
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [15:0]       num,
   input  wire logic [15:0]       den,
   output logic                   busy,
   output logic [FRAC+3:0]        gain
);
   import mhsic_pkg::*;

   localparam int W  = SAMPLE_W + FRAC;
   localparam int GW = FRAC + 4;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   den_ff, den_in;
   logic [16:0]   rem_sh;
   logic [17:0]   diff;
   logic          qbit;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      qbit    = ~diff[17];
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         dvd_in  = {num, {FRAC{1'b0}}};
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
         dvd_in  = {dvd_ff[W-2:0], qbit};
         rem_in  = qbit ? diff[15:0] : rem_sh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_comb begin
      if (den_ff == '0 || (|dvd_ff[W-1:GW])) begin
         gain = '1;
      end else begin
         gain = dvd_ff[GW-1:0];
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mhsic_lane.sv =====
// One axis lane: held reading, min/max tracking, offset and gain correction. Uses mhsic_pkg.
// Correction runs as subtract, multiply, round toward zero, negate if NEGATE, then saturate.
`default_nettype none

module mhsic_lane #(
   parameter int FRAC   = 14,
   parameter bit NEGATE = 1'b1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mhsic_pkg::lane_ctl_type    ctl,
   input  wire logic signed [15:0]         raw,
   input  wire logic [FRAC+3:0]            gain,
   output logic signed [15:0]              held,
   output logic signed [15:0]              corr,
   output logic [15:0]                     rng
);
   import mhsic_pkg::*;

   localparam int GW = FRAC + 4;
   localparam int PW = GW + 18;
   localparam logic signed [PW-1:0] BIAS    = PW'((64'sd1 <<< FRAC) - 64'sd1);
   localparam logic signed [PW-1:0] POS_LIM = PW'(32767);
   localparam logic signed [PW-1:0] NEG_LIM = PW'(-32768);

   logic signed [15:0] held_ff, held_in;
   logic signed [15:0] min_ff, min_in;
   logic signed [15:0] max_ff, max_in;
   logic signed [15:0] off_ff, off_in;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [16:0] sum;
   logic signed [16:0] sum_adj;
   logic signed [GW:0] gain_s;
   logic signed [PW-1:0] prod_b;
   logic signed [PW-1:0] quo;
   logic signed [PW-1:0] quo_n;

   always_comb begin
      held_in = ctl.ld_held ? raw : held_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (ctl.clr_track) begin
         min_in = '0;
         max_in = '0;
      end else if (ctl.track) begin
         if (held_in < min_ff) begin
            min_in = held_in;
         end
         if (held_in > max_ff) begin
            max_in = held_in;
         end
      end
      sum     = {min_ff[15], min_ff} + {max_ff[15], max_ff};
      sum_adj = sum + {16'd0, sum[16]};
      off_in  = ctl.ld_off ? sum_adj[16:1] : off_ff;
      diff_in = {held_ff[15], held_ff} - {off_ff[15], off_ff};
      gain_s  = $signed({1'b0, gain});
      prod_in = gain_s * diff_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
         off_ff  <= '0;
      end else begin
         held_ff <= held_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         off_ff  <= off_in;
      end
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      prod_b = prod_ff + (prod_ff[PW-1] ? BIAS : '0);
      quo    = prod_b >>> FRAC;
      quo_n  = NEGATE ? -quo : quo;
      if (quo_n > POS_LIM) begin
         corr = 16'sh7fff;
      end else if (quo_n < NEG_LIM) begin
         corr = -16'sh8000;
      end else begin
         corr = quo_n[15:0];
      end
   end

   assign held = held_ff;
   assign rng  = max_ff - min_ff;

endmodule

`default_nettype wire

// ===== bench/tb_mag_hard_soft_iron_calibration.sv =====
// Self-checking testbench for the magnetometer hard/soft-iron calibration block.
// A built-in predictor tracks held readings, min/max, offsets and gains and checks every transfer.
// Depends on mhsic_pkg and mag_hard_soft_iron_calibration.

module tb_mag_hard_soft_iron_calibration;
   timeunit 1ns;
   timeprecision 1ps;

   import mhsic_pkg::*;

   localparam int GAIN_FRAC_BITS = 14;
   localparam int GAIN_ONE = 1 << GAIN_FRAC_BITS;
   localparam int GAIN_MAX = (1 << (GAIN_FRAC_BITS + 4)) - 1;
   localparam longint GAIN_SCALE = longint'(1) << GAIN_FRAC_BITS;
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_START = 1'b1;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      status_type  status;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   reading_type pending_readings[$];
   int          error_count = 0;
   int          burst_left = 0;
   bit          no_idle = 1'b0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          rx_cycle = 0;
   int          rx_mode = 0;

   logic [15:0] cal_len;
   mode_type    track_mode;
   logic [15:0] track_count;
   int          held_axis[3];
   int          low_axis[3];
   int          high_axis[3];
   int          offset_axis[3];
   int          gain_y;
   int          gain_z;

   mag_hard_soft_iron_calibration #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic logic [15:0] clamp16(input longint v);
      if (v > 32767) begin
         return 16'h7FFF;
      end
      if (v < -32768) begin
         return 16'h8000;
      end
      return 16'(v);
   endfunction

   function automatic int gain_ratio(input int num, input int den);
      longint q;
      if (den == 0) begin
         return GAIN_MAX;
      end
      q = (longint'(num) << GAIN_FRAC_BITS) / den;
      return (q > GAIN_MAX) ? GAIN_MAX : int'(q);
   endfunction

   function automatic logic [15:0] apply_gain(input int diff, input int gain, input bit negate);
      longint t;
      t = (longint'(gain) * longint'(diff)) / GAIN_SCALE;
      return clamp16(negate ? -t : t);
   endfunction

   task automatic calibrate_and_correct(input logic kind, input logic [15:0] x, y, z,
                                        input logic ovf);
      reading_type r;
      if (kind == REQ_START) begin
         if (track_mode != MODE_CAL) begin
            track_count = '0;
            for (int i = 0; i < 3; i++) begin
               low_axis[i] = 0;
               high_axis[i] = 0;
            end
            track_mode = MODE_CAL;
         end
         r.status = STAT_CAL;
      end else begin
         if (!ovf) begin
            held_axis[0] = int'($signed(x));
            held_axis[1] = int'($signed(y));
            held_axis[2] = int'($signed(z));
         end
         if (track_mode == MODE_CAL) begin
            track_count = track_count + 16'd1;
            if (track_count < cal_len) begin
               for (int i = 0; i < 3; i++) begin
                  if (held_axis[i] < low_axis[i]) low_axis[i] = held_axis[i];
                  if (held_axis[i] > high_axis[i]) high_axis[i] = held_axis[i];
               end
               r.status = STAT_CAL;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  offset_axis[i] = (low_axis[i] + high_axis[i]) / 2;
               end
               gain_y = gain_ratio(high_axis[0] - low_axis[0], high_axis[1] - low_axis[1]);
               gain_z = gain_ratio(high_axis[0] - low_axis[0], high_axis[2] - low_axis[2]);
               track_count = '0;
               for (int i = 0; i < 3; i++) begin
                  low_axis[i] = 0;
                  high_axis[i] = 0;
               end
               track_mode = MODE_DONE;
               r.status = STAT_FINISH;
            end
         end else if (track_mode == MODE_DONE) begin
            r.status = STAT_CORR;
         end else begin
            r.status = STAT_PASS;
         end
      end
      r.x = 16'(held_axis[0]);
      r.y = 16'(held_axis[1]);
      r.z = 16'(held_axis[2]);
      if (kind == REQ_SAMPLE && r.status == STAT_CORR) begin
         r.x = apply_gain(held_axis[0] - offset_axis[0], GAIN_ONE, 1'b1);
         r.y = apply_gain(held_axis[1] - offset_axis[1], gain_y, 1'b1);
         r.z = apply_gain(held_axis[2] - offset_axis[2], gain_z, 1'b0);
      end
      pending_readings.push_back(r);
   endtask

   task automatic send_item(input logic kind, input logic [15:0] x, y, z, input logic ovf);
      int gap;
      if (burst_left == 0) begin
         gap = no_idle ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      req_tuser <= {ovf, kind};
      do @(posedge clock); while (!req_tready);
      calibrate_and_correct(kind, x, y, z, ovf);
   endtask

   task automatic send_start();
      send_item(REQ_START, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                1'($urandom()));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic write_cal_len(input logic [15:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      cal_len = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_axis(input int center, input int spread);
      int v;
      if ($urandom_range(0, 15) == 0) begin
         return 16'($urandom());
      end
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      return clamp16(v);
   endfunction

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[15:0];
         got.y = rsp_tdata[31:16];
         got.z = rsp_tdata[47:32];
         got.status = rsp_tuser;
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer x=%h y=%h z=%h status=%0d",
                                      got.x, got.y, got.z, got.status));
         end else begin
            want = pending_readings.pop_front();
            if (got.x !== want.x)
               report_mismatch($sformatf("out_x %h, predicted %h", got.x, want.x));
            if (got.y !== want.y)
               report_mismatch($sformatf("out_y %h, predicted %h", got.y, want.y));
            if (got.z !== want.z)
               report_mismatch($sformatf("out_z %h, predicted %h", got.z, want.z));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
         end
      end
      rx_cycle++;
      if (rx_cycle % 97 == 0) begin
         rx_mode = $urandom_range(0, 3);
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
               rsp_tready <= ((rx_cycle % 7) < 4);
            end
         endcase
      end
   end

   task automatic test_passthrough();
      send_item(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(REQ_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
      send_item(REQ_SAMPLE, 16'h7FFF, 16'h8000, 16'h0001, 1'b0);
      send_item(REQ_SAMPLE, 16'h5A5A, 16'hA5A5, 16'h1234, 1'b1);
      wait_for_results();
   endtask

   // Calibration starts with the length left by reset, then is cut short by a lower setting.
   task automatic test_reset_length();
      send_start();
      send_item(REQ_SAMPLE, 16'd100, 16'd50, 16'h0000, 1'b0);
      send_item(REQ_SAMPLE, -16'sd100, -16'sd20, 16'd7, 1'b0);
      send_item(REQ_SAMPLE, 16'd900, 16'd900, 16'd900, 1'b1);
      send_start();
      send_item(REQ_SAMPLE, 16'd30, 16'd10, -16'sd9, 1'b0);
      wait_for_results();
      write_cal_len(16'd5);
      send_item(REQ_SAMPLE, 16'd40, 16'd40, 16'd40, 1'b0);
      send_item(REQ_SAMPLE, 16'd200, -16'sd300, 16'd77, 1'b0);
      send_item(REQ_SAMPLE, 16'd0, 16'd0, 16'd0, 1'b1);
      wait_for_results();
   endtask

   // Full-scale x range against a tiny y range and a zero z range saturates both gains.
   task automatic test_extreme_ranges();
      write_cal_len(16'hFFFF);
      send_start();
      send_item(REQ_SAMPLE, 16'h8000, 16'h0010, 16'h0000, 1'b0);
      send_item(REQ_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      wait_for_results();
      write_cal_len(16'd2);
      send_item(REQ_SAMPLE, 16'h1111, 16'h2222, 16'h3333, 1'b0);
      send_item(REQ_SAMPLE, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
      send_item(REQ_SAMPLE, 16'h7FFF, 16'h8000, 16'h8000, 1'b0);
      wait_for_results();
   endtask

   // With x never leaving zero the x range is zero, so a nonzero y range gives a zero gain.
   task automatic test_zero_gain();
      send_start();
      send_item(REQ_SAMPLE, 16'h0000, 16'd100, -16'sd3, 1'b0);
      send_item(REQ_SAMPLE, 16'h0000, 16'd5, 16'd5, 1'b0);
      send_item(REQ_SAMPLE, 16'd250, 16'd250, 16'd250, 1'b0);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_request = 250;
      repeat (40) begin
         send_item(REQ_SAMPLE, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                   ($urandom_range(0, 7) == 0));
      end
      wait_for_results();
      no_idle = 1'b0;
   endtask

   task automatic test_random_calibration();
      int          phase_items;
      int          center[3];
      int          spread[3];
      logic [15:0] len;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 5) begin
            len = 16'($urandom_range(60, 120));
         end else begin
            len = 16'($urandom_range(2, 24));
         end
         write_cal_len(len);
         no_idle = (phase % 3 == 0);
         phase_items = 0;
         while (phase_items < 80) begin
            for (int i = 0; i < 3; i++) begin
               center[i] = int'($urandom_range(0, 40000)) - 20000;
               spread[i] = 1 << $urandom_range(0, 14);
            end
            send_start();
            phase_items++;
            repeat (int'(len) + $urandom_range(5, 30)) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_start();
               end else begin
                  send_item(REQ_SAMPLE, pick_axis(center[0], spread[0]),
                            pick_axis(center[1], spread[1]), pick_axis(center[2], spread[2]),
                            ($urandom_range(0, 7) == 0));
               end
               phase_items++;
            end
         end
         wait_for_results();
      end
   endtask

   initial begin
      cal_len = CAL_SAMPLES_RESET;
      track_mode = MODE_IDLE;
      track_count = '0;
      for (int i = 0; i < 3; i++) begin
         held_axis[i] = 0;
         low_axis[i] = 0;
         high_axis[i] = 0;
         offset_axis[i] = 0;
      end
      gain_y = GAIN_ONE;
      gain_z = GAIN_ONE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough();
      test_reset_length();
      test_extreme_ranges();
      test_zero_gain();
      test_backpressure();
      test_random_calibration();
      wait_for_results();
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mhsic_pkg.sv
rtl/core/mhsic_div.sv
rtl/core/mhsic_lane.sv
rtl/core/mag_hard_soft_iron_calibration.sv
bench/tb_mag_hard_soft_iron_calibration.sv
